@@ rtl/akc_pkg.sv @@
`timescale 1ns / 1ps

package akc_pkg;

  // byte, letter, key length, key word and register index widths
  localparam int DATA_W     = 8;
  localparam int LETTER_W   = 5;
  localparam int KLEN_W     = 5;
  localparam int KEY_WORD_W = 40;
  localparam int CFG_IDX_W  = 2;

  // default sizing
  localparam int AKC_MAX_KEY = 16;
  localparam int QUEUE_DEPTH = 2;

  // alphabet constants
  localparam logic [DATA_W-1:0]   CHAR_UA  = 8'h41;
  localparam logic [DATA_W-1:0]   CHAR_UZ  = 8'h5A;
  localparam logic [DATA_W-1:0]   CHAR_LA  = 8'h61;
  localparam logic [DATA_W-1:0]   CHAR_LZ  = 8'h7A;
  localparam logic [LETTER_W:0]   ALPHA    = 6'd26;
  localparam logic [LETTER_W-1:0] SEEN_MAX = 5'd31;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH  = 2'd3;

  // classified item passed from front to back
  typedef struct packed {
    logic                is_letter;
    logic                start;
    logic [LETTER_W-1:0] letter;
    logic [DATA_W-1:0]   raw;
  } cls_t;

  // configuration seen by the back end
  typedef struct packed {
    logic                  direction;
    logic [KLEN_W-1:0]     key_length;
    logic [KEY_WORD_W-1:0] key_low;
    logic [KEY_WORD_W-1:0] key_high;
  } cfg_t;

endpackage

@@ rtl/autokey_letter_cipher.sv @@
`timescale 1ns / 1ps
// path: input queue, combinational back end, result queue
// throughput: one byte per cycle while the result queue has room, set by
//   the combinational add-mod-26 and plaintext delay-line update
// reset: queues empty, direction encrypt, key length one, key letters zero,
//   letter count zero; the plaintext history is not cleared
module autokey_letter_cipher
  import akc_pkg::*;
#(
  parameter int MAX_KEY = AKC_MAX_KEY
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic [DATA_W-1:0]     in_char,
  input  logic                  message_start,
  output logic                  empty,
  input  logic                  pop,
  output logic [DATA_W-1:0]     out_char,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [KEY_WORD_W-1:0] cfg_data
);

  cfg_t              cfg;
  logic              item_valid;
  logic              item_ready;
  cls_t              item;
  logic              res_valid;
  logic [DATA_W-1:0] res_char;
  logic              res_full;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.direction  <= 1'b0;
      cfg.key_length <= KLEN_W'(1);
      cfg.key_low    <= '0;
      cfg.key_high   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DIRECTION: cfg.direction  <= cfg_data[0];
        REG_KEY_LEN:   cfg.key_length <= cfg_data[KLEN_W-1:0];
        REG_KEY_LOW:   cfg.key_low    <= cfg_data;
        REG_KEY_HIGH:  cfg.key_high   <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: accept and classify
  akc_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .in_char       (in_char),
    .message_start (message_start),
    .full          (full),
    .item_valid    (item_valid),
    .item          (item),
    .item_ready    (item_ready)
  );

  // back: keystream and shift
  akc_back #(
    .MAX_KEY (MAX_KEY)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .item_ready (item_ready),
    .res_valid  (res_valid),
    .res_char   (res_char),
    .res_full   (res_full)
  );

  // result queue
  akc_fifo #(
    .WIDTH (DATA_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_out_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_valid),
    .wdata (res_char),
    .full  (res_full),
    .pop   (pop),
    .rdata (out_char),
    .empty (empty)
  );

endmodule

@@ rtl/akc_fifo.sv @@
`timescale 1ns / 1ps

module akc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push_ok;
  logic             pop_ok;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push_ok, pop_ok})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/akc_front.sv @@
`timescale 1ns / 1ps

module akc_front
  import akc_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] in_char,
  input  logic              message_start,
  output logic              full,
  output logic              item_valid,
  output cls_t              item,
  input  logic              item_ready
);

  cls_t cls;
  logic item_empty;

  // classify the byte and fold case
  always_comb begin
    cls.raw    = in_char;
    cls.start  = message_start;
    cls.is_letter = 1'b0;
    cls.letter = '0;
    if (in_char >= CHAR_UA && in_char <= CHAR_UZ) begin
      cls.is_letter = 1'b1;
      cls.letter    = LETTER_W'(in_char - CHAR_UA);
    end else if (in_char >= CHAR_LA && in_char <= CHAR_LZ) begin
      cls.is_letter = 1'b1;
      cls.letter    = LETTER_W'(in_char - CHAR_LA);
    end
  end

  // queue toward the back end
  akc_fifo #(
    .WIDTH ($bits(cls_t)),
    .DEPTH (DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (cls),
    .full  (full),
    .pop   (item_ready),
    .rdata (item),
    .empty (item_empty)
  );

  assign item_valid = !item_empty;

endmodule

@@ rtl/akc_back.sv @@
`timescale 1ns / 1ps

module akc_back
  import akc_pkg::*;
#(
  parameter int MAX_KEY = AKC_MAX_KEY
) (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              item_valid,
  input  cls_t              item,
  output logic              item_ready,
  output logic              res_valid,
  output logic [DATA_W-1:0] res_char,
  input  logic              res_full
);

  localparam int HIST_IDX_W = (MAX_KEY > 1) ? $clog2(MAX_KEY) : 1;

  logic [LETTER_W-1:0]   hist [MAX_KEY];
  logic [LETTER_W-1:0]   letters_seen;
  logic [LETTER_W-1:0]   letters_seen_next;
  logic [LETTER_W-1:0]   seen_eff;
  logic [KLEN_W-1:0]     klen;
  logic                  use_key;
  logic [3:0]            kidx;
  logic [KEY_WORD_W-1:0] kword;
  logic [LETTER_W-1:0]   kraw;
  logic [LETTER_W-1:0]   kletter;
  logic [HIST_IDX_W-1:0] hist_idx;
  logic [LETTER_W-1:0]   k;
  logic [LETTER_W:0]     sum;
  logic [LETTER_W-1:0]   res;
  logic [LETTER_W-1:0]   plain;
  logic                  fire;

  assign item_ready = !res_full;
  assign fire       = item_valid && !res_full;

  // effective key length, clamped to one and to the history depth
  always_comb begin
    if (cfg.key_length == '0) begin
      klen = KLEN_W'(1);
    end else if (cfg.key_length > KLEN_W'(MAX_KEY)) begin
      klen = KLEN_W'(MAX_KEY);
    end else begin
      klen = cfg.key_length;
    end
  end

  // keystream letter: configured key first, then plaintext history
  always_comb begin
    seen_eff = item.start ? '0 : letters_seen;
    use_key  = ({1'b0, seen_eff} < {1'b0, klen});
    kidx     = seen_eff[3:0];
    kword    = kidx[3] ? cfg.key_high : cfg.key_low;
    kraw     = kword[kidx[2:0] * LETTER_W +: LETTER_W];
    kletter  = ({1'b0, kraw} >= ALPHA) ? LETTER_W'({1'b0, kraw} - ALPHA) : kraw;
    hist_idx = HIST_IDX_W'(klen - KLEN_W'(1));
    k        = use_key ? kletter : hist[hist_idx];
  end

  // add or subtract modulo 26
  always_comb begin
    if (cfg.direction) begin
      sum = {1'b0, item.letter} + ALPHA - {1'b0, k};
    end else begin
      sum = {1'b0, item.letter} + {1'b0, k};
    end
    res   = (sum >= ALPHA) ? LETTER_W'(sum - ALPHA) : LETTER_W'(sum);
    plain = cfg.direction ? res : item.letter;
  end

  // result byte
  assign res_valid = fire;
  assign res_char  = item.is_letter ? (DATA_W'(res) + CHAR_UA) : item.raw;

  // letter count since message start, saturating
  always_comb begin
    letters_seen_next = seen_eff;
    if (item.is_letter && seen_eff != SEEN_MAX) begin
      letters_seen_next = seen_eff + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      letters_seen <= '0;
    end else if (fire) begin
      letters_seen <= letters_seen_next;
    end
  end

  // plaintext delay line, newest at entry 0
  always_ff @(posedge clk) begin
    if (fire && item.is_letter) begin
      hist[0] <= plain;
      for (int i = 1; i < MAX_KEY; i++) begin
        hist[i] <= hist[i-1];
      end
    end
  end

endmodule

@@ tb/autokey_letter_cipher_test.sv @@
`timescale 1ns / 1ps

module autokey_letter_cipher_test;
  import akc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HIST_LEN    = 16;
  localparam int DRAIN_WAIT  = 20;

  typedef struct packed {
    logic [DATA_W-1:0] ch;
    logic              start;
  } byte_item_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  push = 1'b0;
  logic                  full;
  logic [DATA_W-1:0]     in_char = '0;
  logic                  message_start = 1'b0;
  logic                  empty;
  logic                  pop = 1'b0;
  logic [DATA_W-1:0]     out_char;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [KEY_WORD_W-1:0] cfg_data = '0;

  // predictor copy of the registers and the cipher state
  logic                  decrypt_q;
  logic [KLEN_W-1:0]     key_len_q;
  logic [KEY_WORD_W-1:0] key_low_q;
  logic [KEY_WORD_W-1:0] key_high_q;
  logic [LETTER_W-1:0]   plain_hist [HIST_LEN];
  logic [LETTER_W-1:0]   seen_count;

  byte_item_t        pending_bytes [$];
  logic [DATA_W-1:0] expected_chars [$];
  logic [DATA_W-1:0] want_char;
  byte_item_t        next_byte;
  int                idle_pct = 0;
  int                send_gap = 0;
  int                take_gap = 0;
  int                mismatch_count = 0;
  int                cycle_count = 0;

  autokey_letter_cipher dut (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .in_char       (in_char),
    .message_start (message_start),
    .empty         (empty),
    .pop           (pop),
    .out_char      (out_char),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // expected output byte for one input byte, advancing the keystream
  function automatic logic [DATA_W-1:0] cipher_byte(input logic [DATA_W-1:0] ch,
                                                    input logic start);
    int                    letter;
    int                    shift;
    int                    span;
    int                    idx;
    int                    res;
    int                    plain;
    logic [KEY_WORD_W-1:0] word;
    logic [LETTER_W-1:0]   raw_key;
    if (start) seen_count = '0;
    if (ch >= CHAR_UA && ch <= CHAR_UZ) begin
      letter = int'(ch) - int'(CHAR_UA);
    end else if (ch >= CHAR_LA && ch <= CHAR_LZ) begin
      letter = int'(ch) - int'(CHAR_LA);
    end else begin
      return ch;
    end
    // zero length acts as one, long lengths clip to the key size
    if (key_len_q == '0) span = 1;
    else if (int'(key_len_q) > AKC_MAX_KEY) span = AKC_MAX_KEY;
    else span = int'(key_len_q);
    if (int'(seen_count) < span) begin
      idx = int'(seen_count);
      word = (idx < 8) ? key_low_q : key_high_q;
      raw_key = word[LETTER_W*(idx % 8) +: LETTER_W];
      shift = int'(raw_key) % int'(ALPHA);
    end else begin
      shift = int'(plain_hist[span-1]);
    end
    if (!decrypt_q) begin
      res = (letter + shift) % int'(ALPHA);
      plain = letter;
    end else begin
      res = (letter + int'(ALPHA) - shift) % int'(ALPHA);
      plain = res;
    end
    for (int i = HIST_LEN - 1; i > 0; i--) plain_hist[i] = plain_hist[i-1];
    plain_hist[0] = LETTER_W'(plain);
    if (seen_count < SEEN_MAX) seen_count = seen_count + 1'b1;
    return CHAR_UA + DATA_W'(res);
  endfunction

  // input side: one item at a time from the pending queue
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
      send_gap = 0;
    end else if (!(push && full)) begin
      if (push) expected_chars.push_back(cipher_byte(in_char, message_start));
      if (send_gap > 0) begin
        send_gap--;
        push <= 1'b0;
      end else if (pending_bytes.size() != 0) begin
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
          send_gap = $urandom_range(14, 0);
          push <= 1'b0;
        end else begin
          next_byte = pending_bytes.pop_front();
          push <= 1'b1;
          in_char <= next_byte.ch;
          message_start <= next_byte.start;
        end
      end else begin
        push <= 1'b0;
      end
    end
  end

  // output side: take results with random stalls and compare
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      take_gap = 0;
    end else begin
      if (pop && !empty) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: out_char expected none, actual %h", $time, out_char);
          mismatch_count++;
        end else begin
          want_char = expected_chars.pop_front();
          if (out_char !== want_char) begin
            $display("%0t: out_char expected %h, actual %h", $time, want_char, out_char);
            mismatch_count++;
          end
        end
      end
      if (take_gap > 0) begin
        take_gap--;
        pop <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
        take_gap = $urandom_range(14, 0);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL autokey_letter_cipher");
      $finish;
    end
  end

  // register write, mirrored into the predictor on the handshake
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KEY_WORD_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    case (idx)
      REG_DIRECTION: decrypt_q = data[0];
      REG_KEY_LEN:   key_len_q = data[KLEN_W-1:0];
      REG_KEY_LOW:   key_low_q = data;
      REG_KEY_HIGH:  key_high_q = data;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic dir, input logic [KLEN_W-1:0] klen,
                            input logic [KEY_WORD_W-1:0] low,
                            input logic [KEY_WORD_W-1:0] high);
    logic [KEY_WORD_W-1:0] junk;
    // unused upper bits carry random values
    junk = {8'($urandom), 32'($urandom)};
    write_reg(REG_DIRECTION, {junk[KEY_WORD_W-1:1], dir});
    write_reg(REG_KEY_LEN, {junk[KEY_WORD_W-1:KLEN_W], klen});
    write_reg(REG_KEY_LOW, low);
    write_reg(REG_KEY_HIGH, high);
  endtask

  task automatic add_byte(input logic [DATA_W-1:0] ch, input logic start);
    byte_item_t item;
    item.ch = ch;
    item.start = start;
    pending_bytes.push_back(item);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || push || expected_chars.size() != 0);
  endtask

  function automatic logic [KEY_WORD_W-1:0] pick_key_word();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      default: return {8'($urandom), 32'($urandom)};
    endcase
  endfunction

  function automatic logic [KLEN_W-1:0] pick_key_len();
    case ($urandom_range(7))
      0:       return '0;
      1:       return KLEN_W'(1);
      2:       return KLEN_W'(AKC_MAX_KEY);
      3:       return KLEN_W'($urandom_range(31, AKC_MAX_KEY + 1));
      4:       return '1;
      default: return KLEN_W'($urandom_range(AKC_MAX_KEY, 1));
    endcase
  endfunction

  // messages of mostly letters, some other bytes, rare stray restarts
  task automatic add_messages(input int n_items);
    int sent;
    int len;
    int r;
    logic [DATA_W-1:0] ch;
    logic with_start;
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(64, 1);
      with_start = ($urandom_range(9) != 0);
      for (int i = 0; i < len; i++) begin
        r = $urandom_range(99);
        if (r < 45) ch = CHAR_UA + DATA_W'($urandom_range(25));
        else if (r < 75) ch = CHAR_LA + DATA_W'($urandom_range(25));
        else if (r < 88) ch = DATA_W'($urandom_range(255));
        else ch = 8'h20;
        add_byte(ch, (i == 0 && with_start) || $urandom_range(199) == 0);
      end
      sent += len;
    end
  endtask

  // main sequence
  initial begin
    decrypt_q = 1'b0;
    key_len_q = KLEN_W'(1);
    key_low_q = '0;
    key_high_q = '0;
    seen_count = '0;
    for (int i = 0; i < HIST_LEN; i++) plain_hist[i] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset settings, letter boundaries and bytes next to them
    idle_pct = 20;
    add_byte(CHAR_UA, 1'b1);
    add_byte(CHAR_UZ, 1'b0);
    add_byte(CHAR_LA, 1'b0);
    add_byte(CHAR_LZ, 1'b0);
    add_byte(CHAR_UA - 1'b1, 1'b0);
    add_byte(CHAR_UZ + 1'b1, 1'b0);
    add_byte(CHAR_LA - 1'b1, 1'b0);
    add_byte(CHAR_LZ + 1'b1, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b0);
    wait_drained();

    // zero key length, key letters of 31, restart on a space
    set_config(1'b0, '0, '1, '0);
    add_byte(8'h20, 1'b1);
    add_byte("H", 1'b0);
    add_byte("i", 1'b0);
    wait_drained();

    // decrypt with an oversized key length
    set_config(1'b1, '1, pick_key_word(), pick_key_word());
    add_byte("Q", 1'b1);
    add_byte("w", 1'b0);
    add_byte("E", 1'b0);
    add_byte("r", 1'b0);
    add_byte("T", 1'b0);
    wait_drained();

    // key length shrinks in the middle of a message
    write_reg(REG_KEY_LEN, KLEN_W'(2));
    add_byte("y", 1'b0);
    add_byte("U", 1'b0);
    add_byte(8'h2E, 1'b0);
    add_byte("i", 1'b0);
    wait_drained();

    // random settings and traffic
    for (int p = 0; p < 12; p++) begin
      case ($urandom_range(3))
        0:       idle_pct = 0;
        1:       idle_pct = 5;
        2:       idle_pct = 20;
        default: idle_pct = 50;
      endcase
      set_config($urandom_range(1), pick_key_len(), pick_key_word(), pick_key_word());
      add_messages(85);
      wait_drained();
    end

    // full rate at the end
    idle_pct = 0;
    set_config($urandom_range(1), pick_key_len(), pick_key_word(), pick_key_word());
    add_messages(110);
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatch_count == 0 && expected_chars.size() == 0) begin
      $display("PASS autokey_letter_cipher");
    end else begin
      $display("FAIL autokey_letter_cipher");
    end
    $finish;
  end

endmodule

@@ autokey_letter_cipher.f @@
rtl/akc_pkg.sv
rtl/akc_fifo.sv
rtl/akc_front.sv
rtl/akc_back.sv
rtl/autokey_letter_cipher.sv
tb/autokey_letter_cipher_test.sv
